[src/temporal_bilateral_pixel_filter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the temporal bilateral pixel filter
// Clocked, reset-qualified property checks in same-cycle and next-cycle form.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_BILATERAL_PIXEL_FILTER_ASSERT_SVH
`define TEMPORAL_BILATERAL_PIXEL_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TBPF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TBPF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tbpf_pkg.sv]
// ----------------------------------------------------------------------------
// tbpf_pkg
// Types and constants shared by the temporal bilateral pixel filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpf_pkg;

  localparam int unsigned EntryW   = 11;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned TotalW   = 15;
  localparam int unsigned SumW     = 22;
  localparam int unsigned ProdW    = 2 * EntryW;
  localparam int unsigned WeightW  = 14;

  localparam logic [1:0] FuncFilter = 2'd0;
  localparam logic [1:0] FuncRange  = 2'd1;
  localparam logic [1:0] FuncTap    = 2'd2;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};

  typedef struct packed {
    logic [1:0]         func;
    logic [IndexW-1:0]  index;
    logic [SampleW-1:0] sample;
    logic [SampleW-1:0] center_sample;
    logic [EntryW-1:0]  weight_value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [SampleW-1:0] filtered_sample;
    logic               took_center;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StMult,
    StRecip,
    StCorr,
    StAccum,
    StDivide,
    StResult
  } state_e;

  typedef struct packed {
    logic               range_we;
    logic               tap_we;
    logic               rd_en;
    logic [IndexW-1:0]  range_addr;
    logic [IndexW-1:0]  tap_addr;
    logic [EntryW-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [SumW-1:0]   dividend;
    logic [TotalW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SampleW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[src/tbpf_weight_mem.sv]
// ----------------------------------------------------------------------------
// tbpf_weight_mem
// Range-weight and tap-weight tables, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpf_weight_mem #(
  parameter int unsigned MAX_TAPS = 16
) (
  input  wire logic                          clk_i,
  input  wire tbpf_pkg::mem_req_t            req_i,
  output logic [tbpf_pkg::EntryW-1:0]        range_rdata_o,
  output logic [tbpf_pkg::EntryW-1:0]        tap_rdata_o
);

  localparam int unsigned TapAddrW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned RangeDepth = 1 << tbpf_pkg::IndexW;

  logic [tbpf_pkg::EntryW-1:0] range_mem [RangeDepth];
  logic [tbpf_pkg::EntryW-1:0] tap_mem   [MAX_TAPS];

  always_ff @(posedge clk_i) begin
    if (req_i.range_we) begin
      range_mem[req_i.range_addr] <= req_i.wdata;
    end
    if (req_i.tap_we) begin
      tap_mem[req_i.tap_addr[TapAddrW-1:0]] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      range_rdata_o <= range_mem[req_i.range_addr];
      tap_rdata_o   <= tap_mem[req_i.tap_addr[TapAddrW-1:0]];
    end
  end

endmodule

`default_nettype wire

[src/tbpf_divider.sv]
// ----------------------------------------------------------------------------
// tbpf_divider
// Restoring divider, one quotient bit per cycle, quotient saturated to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpf_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tbpf_pkg::div_req_t req_i,
  output tbpf_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned SumW   = tbpf_pkg::SumW;
  localparam int unsigned TotalW = tbpf_pkg::TotalW;
  localparam int unsigned CntW   = $clog2(SumW);
  localparam logic [CntW-1:0] CntLast = CntW'(SumW - 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [TotalW:0]   rem_q;
  logic [SumW-1:0]   quo_q;
  logic [TotalW-1:0] dvs_q;

  logic [TotalW:0]   rem_shift, rem_d;
  logic [SumW-1:0]   quo_d;
  logic              ge;

  always_comb begin
    rem_shift = {rem_q[TotalW-1:0], quo_q[SumW-1]};
    ge        = rem_shift >= {1'b0, dvs_q};
    rem_d     = ge ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
    quo_d     = {quo_q[SumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (quo_q[SumW-1:tbpf_pkg::SampleW] != '0) ?
                          {tbpf_pkg::SampleW{1'b1}} : quo_q[tbpf_pkg::SampleW-1:0];

endmodule

`default_nettype wire

[src/temporal_bilateral_pixel_filter.sv]
// ----------------------------------------------------------------------------
// temporal_bilateral_pixel_filter
// Load item: taken without stalling the input. Filter tap: table read, weight
// multiply, reciprocal multiply, correction, accumulate; the input stalls
// until it is done. Last tap: result set by the 22-step serial divider, or
// the center sample when the total weight is zero. Reset clears control
// state and both accumulators; the weight tables hold no value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_bilateral_pixel_filter #(
  parameter int unsigned MAX_TAPS     = 16,
  parameter int unsigned WEIGHT_SCALE = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tbpf_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tbpf_pkg::out_t      out_data_o
);

  localparam int unsigned EntryW   = tbpf_pkg::EntryW;
  localparam int unsigned SampleW  = tbpf_pkg::SampleW;
  localparam int unsigned TotalW   = tbpf_pkg::TotalW;
  localparam int unsigned SumW     = tbpf_pkg::SumW;
  localparam int unsigned ProdW    = tbpf_pkg::ProdW;
  localparam int unsigned WeightW  = tbpf_pkg::WeightW;
  localparam int unsigned RecipSh  = 32;
  localparam int unsigned RecipW   = 25;
  localparam int unsigned PmW      = ProdW + RecipW;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'((64'd1 << RecipSh) / 64'(WEIGHT_SCALE));
  localparam logic [EntryW-1:0] ScaleV = EntryW'(WEIGHT_SCALE);
  localparam logic [tbpf_pkg::IndexW-1:0] TapLimit = tbpf_pkg::IndexW'(MAX_TAPS);

  tbpf_pkg::state_e state_q, state_d;

  logic [SampleW-1:0] sample_q, center_q;
  logic               last_q, tap_ok_q;
  logic [ProdW-1:0]   prod_q;
  logic [PmW-1:0]     pm_q;
  logic [WeightW-1:0] weight_q;
  logic [TotalW-1:0]  total_q;
  logic [SumW-1:0]    sum_q;
  logic               took_q;
  logic               out_valid_q;
  tbpf_pkg::out_t     out_q;

  logic [EntryW-1:0]  range_rdata, tap_rdata, tw;
  logic               accept, is_filter, tap_ok, out_load;
  tbpf_pkg::mem_req_t mem_req;
  tbpf_pkg::div_req_t div_req;
  tbpf_pkg::div_rsp_t div_rsp;

  logic [SampleW-1:0] diff;
  logic [WeightW-1:0] q0;
  logic [ProdW-1:0]   q0_scaled, rem;
  logic [SumW-1:0]    wprod;
  logic [TotalW:0]    total_add;
  logic [SumW:0]      sum_add;
  logic [TotalW-1:0]  total_new;
  logic [SumW-1:0]    sum_new;

  assign is_filter = in_data_i.func == tbpf_pkg::FuncFilter;
  assign tap_ok    = in_data_i.index < TapLimit;
  assign diff      = (in_data_i.sample >= in_data_i.center_sample) ?
                     (in_data_i.sample - in_data_i.center_sample) :
                     (in_data_i.center_sample - in_data_i.sample);

  always_comb begin
    tw        = tap_ok_q ? tap_rdata : '0;
    q0        = pm_q[RecipSh +: WeightW];
    q0_scaled = ProdW'(q0) * ProdW'(ScaleV);
    rem       = prod_q - q0_scaled;
    wprod     = SumW'(weight_q) * SumW'(sample_q);
    total_add = {1'b0, total_q} + (TotalW + 1)'(weight_q);
    sum_add   = {1'b0, sum_q} + {1'b0, wprod};
    total_new = total_add[TotalW] ? tbpf_pkg::TotalMax : total_add[TotalW-1:0];
    sum_new   = sum_add[SumW] ? tbpf_pkg::SumMax : sum_add[SumW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbpf_pkg::StIdle: begin
        if (in_valid_i && is_filter) begin
          state_d = tbpf_pkg::StMult;
        end
      end
      tbpf_pkg::StMult:  state_d = tbpf_pkg::StRecip;
      tbpf_pkg::StRecip: state_d = tbpf_pkg::StCorr;
      tbpf_pkg::StCorr:  state_d = tbpf_pkg::StAccum;
      tbpf_pkg::StAccum: begin
        if (!last_q) begin
          state_d = tbpf_pkg::StIdle;
        end else if (total_new == '0) begin
          state_d = tbpf_pkg::StResult;
        end else begin
          state_d = tbpf_pkg::StDivide;
        end
      end
      tbpf_pkg::StDivide: begin
        if (div_rsp.done) begin
          state_d = tbpf_pkg::StResult;
        end
      end
      tbpf_pkg::StResult: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = tbpf_pkg::StIdle;
        end
      end
      default: state_d = tbpf_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o         = 1'b1;
    out_load           = 1'b0;
    div_req.start      = 1'b0;
    div_req.dividend   = sum_new;
    div_req.divisor    = total_new;
    case (state_q)
      tbpf_pkg::StIdle:   in_stall_o = 1'b0;
      tbpf_pkg::StAccum:  div_req.start = last_q && (total_new != '0);
      tbpf_pkg::StResult: out_load = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    mem_req.range_we   = accept && (in_data_i.func == tbpf_pkg::FuncRange);
    mem_req.tap_we     = accept && (in_data_i.func == tbpf_pkg::FuncTap) && tap_ok;
    mem_req.rd_en      = accept && is_filter;
    mem_req.range_addr = (in_data_i.func == tbpf_pkg::FuncRange) ? in_data_i.index : diff;
    mem_req.tap_addr   = tap_ok ? in_data_i.index : '0;
    mem_req.wdata      = in_data_i.weight_value;
  end

  tbpf_weight_mem #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mem (
    .clk_i         (clk_i),
    .req_i         (mem_req),
    .range_rdata_o (range_rdata),
    .tap_rdata_o   (tap_rdata)
  );

  tbpf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbpf_pkg::StIdle;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tbpf_pkg::StAccum) begin
        total_q <= last_q ? '0 : total_new;
        sum_q   <= last_q ? '0 : sum_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req.rd_en) begin
      sample_q <= in_data_i.sample;
      center_q <= in_data_i.center_sample;
      last_q   <= in_data_i.last;
      tap_ok_q <= tap_ok;
    end
    if (state_q == tbpf_pkg::StMult) begin
      prod_q <= tw * range_rdata;
    end
    if (state_q == tbpf_pkg::StRecip) begin
      pm_q <= prod_q * RecipM;
    end
    if (state_q == tbpf_pkg::StCorr) begin
      weight_q <= q0 + WeightW'(rem >= ProdW'(ScaleV));
    end
    if (state_q == tbpf_pkg::StAccum) begin
      took_q <= total_new == '0;
    end
    if (out_load) begin
      out_q.filtered_sample <= took_q ? center_q : div_rsp.quotient;
      out_q.took_center     <= took_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/tbpf_checker.sv]
// ----------------------------------------------------------------------------
// tbpf_checker
// Port-level checks of the temporal bilateral pixel filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_bilateral_pixel_filter_assert.svh"

module tbpf_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire tbpf_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire tbpf_pkg::out_t out_data_o
);

  `TBPF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `TBPF_ASSERT_NEXT(a_tap_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.func == tbpf_pkg::FuncFilter), in_stall_o, "no stall after filter tap transfer")
  `TBPF_ASSERT_NEXT(a_load_free, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.func != tbpf_pkg::FuncFilter), !in_stall_o, "stall after load transfer")
  `TBPF_ASSERT_SAME(a_result_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without filter work")

endmodule

bind temporal_bilateral_pixel_filter tbpf_checker u_tbpf_checker (.*);

`default_nettype wire

[tb/sv/temporal_bilateral_pixel_filter_test.sv]
// ----------------------------------------------------------------------------
// temporal_bilateral_pixel_filter_test
// Self-checking bench for the temporal bilateral pixel filter. Fills both
// weight tables, runs directed windows for saturation, zero-weight pass-through
// and ignored items, then random windows mixed with table rewrites, noise items
// and unterminated windows, with and without random idling, and under one long
// output hold-off. Every result is compared with an in-bench prediction of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_bilateral_pixel_filter_test;

  localparam int unsigned SampleW     = tbpf_pkg::SampleW;
  localparam int unsigned EntryW      = tbpf_pkg::EntryW;
  localparam int unsigned IndexW      = tbpf_pkg::IndexW;
  localparam int unsigned MaxTaps     = 16;
  localparam int unsigned TapIdxW     = $clog2(MaxTaps);
  localparam int unsigned WeightScale = 1024;
  localparam int unsigned RangeDepth  = 256;
  localparam int unsigned SampleMax   = (1 << SampleW) - 1;
  localparam int unsigned EntryMax    = (1 << EntryW) - 1;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned HoldCycles  = 600;
  localparam logic [1:0]  FuncUnused  = 2'd3;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  tbpf_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  tbpf_pkg::out_t out_data_o;

  temporal_bilateral_pixel_filter #(
    .MAX_TAPS    (MaxTaps),
    .WEIGHT_SCALE(WeightScale)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  logic [EntryW-1:0] range_weight [RangeDepth];
  logic [EntryW-1:0] tap_weight [MaxTaps];
  int unsigned       acc_weight = 0;
  int unsigned       acc_sum = 0;
  tbpf_pkg::out_t    expected_pixels [$];
  tbpf_pkg::out_t    want_pixel;
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       taps_sent = 0;
  bit                sender_idles = 1'b0;
  bit                receiver_idles = 1'b0;
  bit                receiver_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic void predict_pixel(tbpf_pkg::in_t it);
    logic [SampleW-1:0] diff;
    int unsigned        tw;
    int unsigned        w;
    int unsigned        prod;
    int unsigned        quot;
    tbpf_pkg::out_t     res;
    case (it.func)
      tbpf_pkg::FuncRange: range_weight[it.index] = it.weight_value;
      tbpf_pkg::FuncTap: begin
        if (it.index < MaxTaps) tap_weight[it.index[TapIdxW-1:0]] = it.weight_value;
      end
      tbpf_pkg::FuncFilter: begin
        diff = (it.sample >= it.center_sample) ? it.sample - it.center_sample
                                               : it.center_sample - it.sample;
        tw   = (it.index < MaxTaps) ? tap_weight[it.index[TapIdxW-1:0]] : 0;
        w    = (tw * range_weight[diff]) / WeightScale;
        prod = w * it.sample;
        if (prod > tbpf_pkg::SumMax) prod = tbpf_pkg::SumMax;
        acc_weight = acc_weight + w;
        if (acc_weight > tbpf_pkg::TotalMax) acc_weight = tbpf_pkg::TotalMax;
        acc_sum = acc_sum + prod;
        if (acc_sum > tbpf_pkg::SumMax) acc_sum = tbpf_pkg::SumMax;
        if (it.last) begin
          if (acc_weight > 0) begin
            quot = acc_sum / acc_weight;
            res.filtered_sample = SampleW'((quot > SampleMax) ? SampleMax : quot);
            res.took_center     = 1'b0;
          end else begin
            res.filtered_sample = it.center_sample;
            res.took_center     = 1'b1;
          end
          expected_pixels.push_back(res);
          acc_weight = 0;
          acc_sum    = 0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (receiver_hold) begin
      out_stall_i <= 1'b1;
    end else if (receiver_idles) begin
      out_stall_i <= ($urandom_range(99) < 33);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing expected", out_data_o.filtered_sample, 0);
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (out_data_o.filtered_sample !== want_pixel.filtered_sample)
          report_mismatch("filtered_sample", out_data_o.filtered_sample,
                          want_pixel.filtered_sample);
        if (out_data_o.took_center !== want_pixel.took_center)
          report_mismatch("took_center", out_data_o.took_center, want_pixel.took_center);
      end
    end
  end

  function automatic tbpf_pkg::in_t make_item(logic [1:0] func, int unsigned index,
                                              int unsigned sample, int unsigned center,
                                              int unsigned wval, bit last);
    tbpf_pkg::in_t it;
    it.func          = func;
    it.index         = IndexW'(index);
    it.sample        = SampleW'(sample);
    it.center_sample = SampleW'(center);
    it.weight_value  = EntryW'(wval);
    it.last          = last;
    return it;
  endfunction

  function automatic int unsigned rand_entry();
    case ($urandom_range(7))
      0:       return 0;
      1:       return WeightScale;
      2:       return EntryMax;
      default: return $urandom_range(EntryMax);
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(tbpf_pkg::in_t it);
    if (sender_idles) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pixel(it);
    if (it.func != FuncUnused) taps_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_tables();
    for (int unsigned i = 0; i < RangeDepth; i++)
      send_item(make_item(tbpf_pkg::FuncRange, i, $urandom_range(SampleMax),
                          $urandom_range(SampleMax), rand_entry(),
                          $urandom_range(1) != 0));
    for (int unsigned i = 0; i < MaxTaps; i++)
      send_item(make_item(tbpf_pkg::FuncTap, i, $urandom_range(SampleMax),
                          $urandom_range(SampleMax), rand_entry(),
                          $urandom_range(1) != 0));
  endtask

  task automatic test_directed();
    // saturate both accumulators
    send_item(make_item(tbpf_pkg::FuncTap, 0, 0, 0, EntryMax, 0));
    send_item(make_item(tbpf_pkg::FuncRange, 0, 0, 0, EntryMax, 0));
    for (int unsigned i = 0; i < 9; i++)
      send_item(make_item(tbpf_pkg::FuncFilter, 0, SampleMax, SampleMax, 0, i == 8));
    // zero range weight passes center through
    send_item(make_item(tbpf_pkg::FuncRange, SampleMax, 0, 0, 0, 0));
    send_item(make_item(tbpf_pkg::FuncFilter, 0, 0, SampleMax, 0, 1));
    // tap beyond the table adds nothing
    send_item(make_item(tbpf_pkg::FuncFilter, SampleMax, SampleMax, 0, EntryMax, 1));
    // out-of-range tap write is dropped
    send_item(make_item(tbpf_pkg::FuncTap, 200, 0, 0, 0, 0));
    send_item(make_item(tbpf_pkg::FuncFilter, 0, 200, 200, 0, 1));
    send_item(make_item(FuncUnused, 0, SampleMax, 0, EntryMax, 1));
    // unity weights
    send_item(make_item(tbpf_pkg::FuncTap, 1, 0, 0, WeightScale, 0));
    send_item(make_item(tbpf_pkg::FuncRange, 3, 0, 0, WeightScale, 0));
    send_item(make_item(tbpf_pkg::FuncFilter, 1, 10, 13, 0, 0));
    send_item(make_item(tbpf_pkg::FuncFilter, 1, 16, 13, 0, 0));
    send_item(make_item(tbpf_pkg::FuncFilter, 0, 13, 13, 0, 1));
    // smallest nonzero weight
    send_item(make_item(tbpf_pkg::FuncTap, 2, 0, 0, 1, 0));
    send_item(make_item(tbpf_pkg::FuncFilter, 2, 0, 0, 0, 1));
    wait_drained();
  endtask

  task automatic send_window(int unsigned taps, bit closed);
    int unsigned center;
    int unsigned index;
    int unsigned sample;
    int unsigned roll;
    center = $urandom_range(SampleMax);
    for (int unsigned t = 0; t < taps; t++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_item(make_item(tbpf_pkg::FuncRange, $urandom_range(SampleMax),
                            $urandom_range(SampleMax), $urandom_range(SampleMax),
                            rand_entry(), $urandom_range(1) != 0));
      end else if (roll < 5) begin
        send_item(make_item(tbpf_pkg::FuncTap,
                            $urandom_range(1) ? $urandom_range(MaxTaps - 1)
                                              : $urandom_range(SampleMax),
                            $urandom_range(SampleMax), $urandom_range(SampleMax),
                            rand_entry(), $urandom_range(1) != 0));
      end else if (roll < 7) begin
        send_item(make_item(FuncUnused, $urandom_range(SampleMax), $urandom_range(SampleMax),
                            $urandom_range(SampleMax), $urandom_range(EntryMax),
                            $urandom_range(1) != 0));
      end
      index = ($urandom_range(9) == 0) ? $urandom_range(SampleMax) : t;
      if ($urandom_range(1)) begin
        sample = $urandom_range(SampleMax);
      end else begin
        sample = center + $urandom_range(8);
        if (sample > SampleMax) sample = SampleMax;
      end
      if ($urandom_range(19) == 0) center = $urandom_range(SampleMax);
      send_item(make_item(tbpf_pkg::FuncFilter, index, sample, center,
                          $urandom_range(EntryMax), closed && (t == taps - 1)));
    end
  endtask

  task automatic send_random_windows(int unsigned count);
    int unsigned stop_at;
    int unsigned taps;
    stop_at = taps_sent + count;
    while (taps_sent < stop_at) begin
      taps = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, MaxTaps);
      send_window(taps, $urandom_range(9) != 0);
    end
  endtask

  task automatic test_random();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    send_random_windows(60);
    // pause the sender until everything is out
    wait_drained();
    send_random_windows(60);
  endtask

  task automatic test_no_idle();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    send_random_windows(40);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_backpressure();
    fork
      begin
        receiver_hold <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        receiver_hold <= 1'b0;
      end
    join_none
    for (int unsigned i = 0; i < 60; i++) send_window(1, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    load_tables();
    test_directed();
    test_random();
    test_no_idle();
    test_backpressure();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/tbpf_pkg.sv
src/tbpf_weight_mem.sv
src/tbpf_divider.sv
src/temporal_bilateral_pixel_filter.sv
src/tbpf_checker.sv
tb/sv/temporal_bilateral_pixel_filter_test.sv
